// ----- sv/svac_pkg.sv -----
`timescale 1ns / 1ps

package svac_pkg;

  // Number of voice slots in the table.
  localparam int VOICES = 16;
  localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  // Slots that are shown in the 16-bit active mask.
  localparam int MASK_N = (VOICES < 16) ? VOICES : 16;

  // Request codes.
  localparam logic [1:0] REQ_TRIGGER = 2'd0;
  localparam logic [1:0] REQ_STOP    = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_STARTED  = 2'd0;
  localparam logic [1:0] STS_REJECTED = 2'd1;
  localparam logic [1:0] STS_STOPPED  = 2'd2;
  localparam logic [1:0] STS_TICKED   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              clamp_st;
    logic              clamp_len;
    logic              choke_chk;
    logic              alloc;
    logic              stop_clear;
    logic              tick_add;
    logic              tick_mul;
    logic              tick_cmp;
    logic              emit;
    logic [1:0]        emit_status;
    logic [SLOT_W-1:0] idx;
  } svac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic choke_en;
  } svac_sts_t;

endpackage

// ----- sv/svac_ctrl.sv -----
`timescale 1ns / 1ps

module svac_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_req_type,
  input  svac_pkg::svac_sts_t   sts,
  output svac_pkg::svac_cmd_t   cmd,
  output logic                  busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP_ST,
    S_CLAMP_LEN,
    S_CHOKE,
    S_ALLOC,
    S_STOP,
    S_TICK_ADD,
    S_TICK_MUL,
    S_TICK_CMP,
    S_EMIT
  } state_t;

  localparam logic [svac_pkg::SLOT_W-1:0] LAST_IDX =
    svac_pkg::SLOT_W'(svac_pkg::VOICES - 1);

  state_t                      state_r, state_nxt;
  logic [svac_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          case (in_req_type)
            svac_pkg::REQ_TRIGGER: state_nxt = S_CLAMP_ST;
            svac_pkg::REQ_STOP:    state_nxt = S_STOP;
            svac_pkg::REQ_TICK:    state_nxt = S_TICK_ADD;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLAMP_ST: begin
        if (sts.reject) begin
          status_nxt = svac_pkg::STS_REJECTED;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_CLAMP_LEN;
        end
      end
      S_CLAMP_LEN: state_nxt = sts.choke_en ? S_CHOKE : S_ALLOC;
      S_CHOKE: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        status_nxt = svac_pkg::STS_STARTED;
        state_nxt  = S_EMIT;
      end
      S_STOP: begin
        status_nxt = svac_pkg::STS_STOPPED;
        state_nxt  = S_EMIT;
      end
      S_TICK_ADD: state_nxt = S_TICK_MUL;
      S_TICK_MUL: state_nxt = S_TICK_CMP;
      S_TICK_CMP: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          status_nxt = svac_pkg::STS_TICKED;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_TICK_ADD;
        end
      end
      S_EMIT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      status_r <= svac_pkg::STS_STARTED;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.idx         = idx_r;
    cmd.emit_status = status_r;
    cmd.load        = accept;
    cmd.clamp_st    = (state_r == S_CLAMP_ST);
    cmd.clamp_len   = (state_r == S_CLAMP_LEN);
    cmd.choke_chk   = (state_r == S_CHOKE);
    cmd.alloc       = (state_r == S_ALLOC);
    cmd.stop_clear  = (state_r == S_STOP);
    cmd.tick_add    = (state_r == S_TICK_ADD);
    cmd.tick_mul    = (state_r == S_TICK_MUL);
    cmd.tick_cmp    = (state_r == S_TICK_CMP);
    cmd.emit        = (state_r == S_EMIT);
  end

endmodule

// ----- sv/svac_dp.sv -----
`timescale 1ns / 1ps

module svac_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  svac_pkg::svac_cmd_t cmd,
  output svac_pkg::svac_sts_t sts,
  input  logic [15:0]         in_buffer_id,
  input  logic [23:0]         in_buffer_frames,
  input  logic signed [24:0]  in_start_frame,
  input  logic signed [24:0]  in_play_length,
  input  logic [15:0]         in_voice_gain_in,
  input  logic signed [15:0]  in_voice_pan_in,
  input  logic signed [7:0]   in_choke_group,
  input  logic [31:0]         in_rate_ratio,
  input  logic [12:0]         in_tick_frames,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [3:0]          out_slot,
  output logic                out_stole_voice,
  output logic [15:0]         out_active_mask,
  output logic [23:0]         out_eff_start,
  output logic [23:0]         out_eff_length,
  output logic signed [15:0]  out_eff_pan
);

  localparam int N = svac_pkg::VOICES;
  localparam int SW = svac_pkg::SLOT_W;

  // Voice table.
  logic [N-1:0] active_r;
  logic [15:0]  vbuf_r   [N];
  logic [23:0]  vstart_r [N];
  logic [23:0]  vlen_r   [N];
  logic [31:0]  vpos_r   [N];
  logic [31:0]  vratio_r [N];
  logic [15:0]  vgain_r  [N];
  logic [15:0]  vpan_r   [N];
  logic [6:0]   vchoke_r [N];

  // Captured request.
  logic [15:0]        buf_r;
  logic [23:0]        frames_r;
  logic signed [24:0] st_in_r;
  logic signed [24:0] len_in_r;
  logic [15:0]        gain_r;
  logic signed [15:0] pan_r;
  logic [6:0]         ch_r;
  logic [31:0]        ratio_r;
  logic [12:0]        tf_r;
  logic               reject_r;
  logic [23:0]        st_r;
  logic [23:0]        len_r;

  // Tick pipeline for one slot.
  logic        tact_r;
  logic [31:0] tpos_r;
  logic [31:0] tratio_r;
  logic [23:0] tlen_r;
  logic [63:0] prod_r;

  // Result of the allocation.
  logic [SW-1:0] res_slot_r;
  logic          res_stole_r;

  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [3:0]          out_slot_r;
  logic                out_stole_r;
  logic [15:0]         out_mask_r;
  logic [23:0]         out_start_r;
  logic [23:0]         out_len_r;
  logic signed [15:0]  out_pan_r;

  logic signed [15:0] pan_clamped;
  logic signed [25:0] st_ext, fr_last;
  logic [23:0]        st_clamped;
  logic signed [25:0] len_ext, rem_ext;
  logic [23:0]        len_clamped;
  logic [SW-1:0]      free_idx;
  logic               free_found;
  logic [32:0]        pos_sum;
  logic [31:0]        pos_sat;
  logic [15:0]        mask;

  assign sts.reject   = reject_r;
  assign sts.choke_en = (ch_r != 7'd0);

  always_comb begin
    if (in_voice_pan_in < -16'sd16384) begin
      pan_clamped = -16'sd16384;
    end else if (in_voice_pan_in > 16'sd16384) begin
      pan_clamped = 16'sd16384;
    end else begin
      pan_clamped = in_voice_pan_in;
    end
  end

  always_comb begin
    st_ext  = 26'(st_in_r);
    fr_last = $signed({2'b00, frames_r}) - 26'sd1;
    if (st_ext < 26'sd0) begin
      st_clamped = '0;
    end else if (st_ext > fr_last) begin
      st_clamped = fr_last[23:0];
    end else begin
      st_clamped = st_ext[23:0];
    end
  end

  always_comb begin
    len_ext = 26'(len_in_r);
    rem_ext = $signed({2'b00, frames_r}) - $signed({2'b00, st_r});
    if (len_ext < 26'sd1) begin
      len_ext = 26'sd1;
    end
    if (len_ext > rem_ext) begin
      len_ext = rem_ext;
    end
    len_clamped = len_ext[23:0];
  end

  // First free slot, lowest index wins.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (!free_found && !active_r[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  // Saturating position update.
  always_comb begin
    pos_sum = {1'b0, vpos_r[cmd.idx]} + {20'd0, tf_r};
    pos_sat = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < svac_pkg::MASK_N; i++) begin
      mask[i] = active_r[i];
    end
  end

  // Request capture and per-step datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_r    <= in_buffer_id;
      frames_r <= in_buffer_frames;
      st_in_r  <= in_start_frame;
      len_in_r <= in_play_length;
      gain_r   <= in_voice_gain_in;
      pan_r    <= pan_clamped;
      ch_r     <= in_choke_group[7] ? 7'd0 : in_choke_group[6:0];
      ratio_r  <= in_rate_ratio;
      tf_r     <= in_tick_frames;
      reject_r <= (in_buffer_id == 16'd0) || (in_buffer_frames < 24'd2);
    end
    if (cmd.clamp_st) begin
      st_r <= st_clamped;
    end
    if (cmd.clamp_len) begin
      len_r <= len_clamped;
    end
    if (cmd.alloc) begin
      res_slot_r               <= free_found ? free_idx : '0;
      res_stole_r              <= !free_found;
      vbuf_r[free_idx]   <= buf_r;
      vstart_r[free_idx] <= st_r;
      vlen_r[free_idx]   <= len_r;
      vpos_r[free_idx]   <= '0;
      vratio_r[free_idx] <= ratio_r;
      vgain_r[free_idx]  <= gain_r;
      vpan_r[free_idx]   <= pan_r;
      vchoke_r[free_idx] <= ch_r;
    end
    if (cmd.tick_add) begin
      tact_r   <= active_r[cmd.idx];
      tpos_r   <= pos_sat;
      tratio_r <= vratio_r[cmd.idx];
      tlen_r   <= vlen_r[cmd.idx];
      if (active_r[cmd.idx]) begin
        vpos_r[cmd.idx] <= pos_sat;
      end
    end
    if (cmd.tick_mul) begin
      prod_r <= 64'(tpos_r) * 64'(tratio_r);
    end
  end

  // Active flags. When no slot is free, free_idx is zero, which is the
  // slot that gets overwritten.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      if (cmd.choke_chk && active_r[cmd.idx] && (vchoke_r[cmd.idx] == ch_r)) begin
        active_r[cmd.idx] <= 1'b0;
      end
      if (cmd.alloc) begin
        active_r[free_idx] <= 1'b1;
      end
      if (cmd.stop_clear) begin
        active_r <= '0;
      end
      if (cmd.tick_cmp && tact_r && (prod_r >= {24'd0, tlen_r, 16'd0})) begin
        active_r[cmd.idx] <= 1'b0;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_mask_r   <= mask;
      if (cmd.emit_status == svac_pkg::STS_STARTED) begin
        out_slot_r  <= 4'(res_slot_r);
        out_stole_r <= res_stole_r;
        out_start_r <= st_r;
        out_len_r   <= len_r;
        out_pan_r   <= pan_r;
      end else begin
        out_slot_r  <= '0;
        out_stole_r <= 1'b0;
        out_start_r <= '0;
        out_len_r   <= '0;
        out_pan_r   <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_stole_voice = out_stole_r;
  assign out_active_mask = out_mask_r;
  assign out_eff_start   = out_start_r;
  assign out_eff_length  = out_len_r;
  assign out_eff_pan     = out_pan_r;

endmodule

// ----- sv/sampler_voice_allocator_choke_top.sv -----
`timescale 1ns / 1ps

// Sample-playback voice allocator with choke groups.
// An item is accepted at a rising clock edge where start is high and busy is
// low; its fields arrive on the in_ ports in that same cycle. The request
// type selects a trigger, a stop of all voices or a time tick. A request
// type of 3 is accepted and ignored: it produces no result and busy stays low.
// Every other item produces exactly one result item, shown on the out_ ports
// for a single cycle with out_valid high. The receiver cannot stall the
// block, so results are never held or repeated.
// Steps: a stop clears all voices; a trigger clamps the start and then the
// length, then checks one slot per cycle against the new choke group when
// it has one, and allocates a slot; a rejected trigger skips from the start
// clamp to its result; a tick takes every slot in turn through a saturating
// add, a 32x32 multiply and a compare, with one shared multiplier.
// One item is worked on at a time; busy drops in the cycle that shows the
// result, so the next item can be taken there.
// A synchronous reset (rst_n low) marks all voices inactive and clears the
// controller; other table fields have no reset and serve only active slots.
module sampler_voice_allocator_choke_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_buffer_id,
  input  logic [23:0]        in_buffer_frames,
  input  logic signed [24:0] in_start_frame,
  input  logic signed [24:0] in_play_length,
  input  logic [15:0]        in_voice_gain_in,
  input  logic signed [15:0] in_voice_pan_in,
  input  logic signed [7:0]  in_choke_group,
  input  logic [31:0]        in_rate_ratio,
  input  logic [12:0]        in_tick_frames,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [3:0]         out_slot,
  output logic               out_stole_voice,
  output logic [15:0]        out_active_mask,
  output logic [23:0]        out_eff_start,
  output logic [23:0]        out_eff_length,
  output logic signed [15:0] out_eff_pan
);

  svac_pkg::svac_cmd_t cmd;
  svac_pkg::svac_sts_t sts;

  // The controller sequences each item and sweeps the slot index.
  svac_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  // The datapath holds the voice table, the clamping logic, the tick
  // multiplier and the result registers.
  svac_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_buffer_id     (in_buffer_id),
    .in_buffer_frames (in_buffer_frames),
    .in_start_frame   (in_start_frame),
    .in_play_length   (in_play_length),
    .in_voice_gain_in (in_voice_gain_in),
    .in_voice_pan_in  (in_voice_pan_in),
    .in_choke_group   (in_choke_group),
    .in_rate_ratio    (in_rate_ratio),
    .in_tick_frames   (in_tick_frames),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_stole_voice  (out_stole_voice),
    .out_active_mask  (out_active_mask),
    .out_eff_start    (out_eff_start),
    .out_eff_length   (out_eff_length),
    .out_eff_pan      (out_eff_pan)
  );

endmodule
